// File: rtl/sha1s_pkg.sv
`timescale 1ns / 1ps

package sha1s_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] chain_t;

	// initial chaining values, entry 0 is h0
	localparam chain_t SHA1_IV = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam word_t K_R0 = 32'h5a827999;
	localparam word_t K_R1 = 32'h6ed9eba1;
	localparam word_t K_R2 = 32'h8f1bbcdc;
	localparam word_t K_R3 = 32'hca62c1d6;

	localparam logic [6:0] ROUND_B1   = 7'd20;
	localparam logic [6:0] ROUND_B2   = 7'd40;
	localparam logic [6:0] ROUND_B3   = 7'd60;
	localparam logic [6:0] ROUND_LAST = 7'd79;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
	localparam logic [5:0] FILL_LAST     = 6'd63;
	localparam logic [5:0] FILL_LEN      = 6'd56;
	localparam logic [2:0] WORD_LAST     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUNDS,
		ST_ADD,
		ST_EMIT
	} state_t;

	// commands from the sequencer to the round datapath
	typedef struct packed {
		logic       shift_byte;
		logic [7:0] byte_val;
		logic       load_wv;
		logic       do_round;
		logic       add_chain;
		logic       init_chain;
	} cmd_t;

endpackage

// File: rtl/sha1_stream_hash.sv
`timescale 1ns / 1ps

// streaming sha-1 digest engine
// input channel (msg_valid/msg_ready): one request per message byte, with
// has_byte qualifying message_byte and end_of_message closing the message
// after this request's byte, if any
// output channel (digest_valid/digest_ready): five requests per message,
// digest_word with word_index 0 (most significant) to 4, last_word on the fifth
// bytes shift one per cycle into a 512-bit window while msg_ready is high;
// every 64th byte starts a block: 80 rounds on one shared round unit, then
// a fold into the chaining words, with msg_ready low through rounds and fold
// end of message: the 0x80 marker goes in at the fill position p, then zero
// bytes follow one per cycle up to position 56, one turn state, and the eight
// length bytes to the block end; when p >= 56 the zeros run to the block end,
// that block is hashed, and a further block of zeros and the length follows;
// then the rounds of the last block and the hand-over of the digest words
// a stalled receiver holds the engine in the hand-over until the fifth word is
// loaded into the output register; msg_ready comes back as it is loaded
// reset: chaining words to the initial values, byte count and fill cleared,
// output channel empty, engine idle and ready

module sha1_stream_hash import sha1s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [7:0]  message_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t      state_q, state_d;
	state_t      ret_q, ret_d;      // where to go after the chaining add
	logic [5:0]  fill_q;            // byte position in the current block
	logic [60:0] count_q;           // message length in bytes, wraps
	logic [2:0]  idx_q;             // next digest word to hand over

	cmd_t        cmd;
	logic        last_round;
	chain_t      chain;

	logic        accept;
	logic        fill_inc;
	logic        count_inc;
	logic        clear_msg;
	logic        emit_go;
	logic        wrap;
	logic [63:0] len_bits;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;

	logic        digest_valid_q;
	logic [31:0] digest_word_q;
	logic [2:0]  word_index_q;
	logic        last_word_q;

	assign accept  = msg_valid && msg_ready;
	assign wrap    = (fill_q == FILL_LAST);
	assign emit_go = (state_q == ST_EMIT) && (!digest_valid_q || digest_ready);

	// length field, most significant byte first at fill 56
	assign len_bits = {count_q, 3'b000};
	assign len_sel  = 3'd7 - fill_q[2:0];
	assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (has_byte && wrap) begin
						state_d = ST_ROUNDS;
						ret_d   = end_of_message ? ST_PAD_MARK : ST_IDLE;
					end else if (end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				if (wrap) begin
					state_d = ST_ROUNDS;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (fill_q == FILL_LEN) begin
					state_d = ST_PAD_LEN;
				end else if (wrap) begin
					state_d = ST_ROUNDS;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (wrap) begin
					state_d = ST_ROUNDS;
					ret_d   = ST_EMIT;
				end
			end
			ST_ROUNDS: begin
				if (last_round) state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_EMIT: begin
				if (emit_go && idx_q == WORD_LAST) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd       = '0;
		msg_ready = 1'b0;
		fill_inc  = 1'b0;
		count_inc = 1'b0;
		clear_msg = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (accept && has_byte) begin
					cmd.shift_byte = 1'b1;
					cmd.byte_val   = message_byte;
					cmd.load_wv    = wrap;
					fill_inc       = 1'b1;
					count_inc      = 1'b1;
				end
			end
			ST_PAD_MARK: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_val   = PAD_MARK_BYTE;
				cmd.load_wv    = wrap;
				fill_inc       = 1'b1;
			end
			ST_PAD_ZERO: begin
				if (fill_q != FILL_LEN) begin
					cmd.shift_byte = 1'b1;
					cmd.byte_val   = PAD_ZERO_BYTE;
					cmd.load_wv    = wrap;
					fill_inc       = 1'b1;
				end
			end
			ST_PAD_LEN: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_val   = len_byte;
				cmd.load_wv    = wrap;
				fill_inc       = 1'b1;
			end
			ST_ROUNDS: begin
				cmd.do_round = 1'b1;
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
			end
			ST_EMIT: begin
				if (emit_go && idx_q == WORD_LAST) begin
					cmd.init_chain = 1'b1;
					clear_msg      = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ret_q          <= ST_IDLE;
			fill_q         <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			digest_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (clear_msg) begin
				fill_q  <= '0;
				count_q <= '0;
			end else begin
				if (fill_inc)  fill_q  <= fill_q + 6'd1;
				if (count_inc) count_q <= count_q + 61'd1;
			end
			if (emit_go) begin
				idx_q          <= (idx_q == WORD_LAST) ? 3'd0 : idx_q + 3'd1;
				digest_valid_q <= 1'b1;
			end else if (digest_ready) begin
				digest_valid_q <= 1'b0;
			end
		end
	end

	// output register, payload only
	always_ff @(posedge clk) begin
		if (emit_go) begin
			digest_word_q <= chain[idx_q];
			word_index_q  <= idx_q;
			last_word_q   <= (idx_q == WORD_LAST);
		end
	end

	sha1s_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.last_round (last_round),
		.chain      (chain)
	);

	assign digest_valid = digest_valid_q;
	assign digest_word  = digest_word_q;
	assign word_index   = word_index_q;
	assign last_word    = last_word_q;

	// a block only runs once its window is full
	a_rounds_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUNDS |-> fill_q == 6'd0)
		else $error("rounds running on a partly filled block");

	// the chaining add follows the round loop only
	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> $past(state_q) == ST_ROUNDS)
		else $error("chaining add without rounds");

	// length bytes go into the last eight positions only
	a_len_place: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD_LEN |-> fill_q >= FILL_LEN)
		else $error("length field outside the block tail");

	// digest words follow each other without a gap, in order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !last_word |=>
		digest_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word sequence broken");

endmodule

// File: rtl/sha1s_core.sv
`timescale 1ns / 1ps

module sha1s_core import sha1s_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	output logic   last_round,
	output chain_t chain
);

	logic [511:0] win_q;      // block bytes, then rolling schedule window
	chain_t       wv_q;       // a..e, a at entry 0
	chain_t       chain_q;
	logic [6:0]   round_q;

	word_t w0, w2, w8, w13, w_new;
	word_t a, b, c, d, e, f, k, tmp;

	// word j of the window is W[t+j]
	assign w0  = win_q[511 -: 32];
	assign w2  = win_q[511 - 2 * 32 -: 32];
	assign w8  = win_q[511 - 8 * 32 -: 32];
	assign w13 = win_q[511 - 13 * 32 -: 32];

	always_comb begin
		w_new = w13 ^ w8 ^ w2 ^ w0;
		w_new = {w_new[30:0], w_new[31]};
	end

	assign a = wv_q[0];
	assign b = wv_q[1];
	assign c = wv_q[2];
	assign d = wv_q[3];
	assign e = wv_q[4];

	always_comb begin
		priority if (round_q < ROUND_B1) begin
			f = (b & c) ^ (~b & d);
			k = K_R0;
		end else if (round_q < ROUND_B2) begin
			f = b ^ c ^ d;
			k = K_R1;
		end else if (round_q < ROUND_B3) begin
			f = (b & c) ^ (b & d) ^ (c & d);
			k = K_R2;
		end else begin
			f = b ^ c ^ d;
			k = K_R3;
		end
		tmp = {a[26:0], a[31:27]} + f + e + k + w0;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			win_q <= {win_q[503:0], cmd.byte_val};
		end else if (cmd.do_round) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.load_wv) begin
			wv_q <= chain_q;
		end else if (cmd.do_round) begin
			wv_q <= {d, c, {b[1:0], b[31:2]}, a, tmp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SHA1_IV;
			round_q <= '0;
		end else begin
			if (cmd.init_chain) begin
				chain_q <= SHA1_IV;
			end else if (cmd.add_chain) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
			end
			if (cmd.load_wv) begin
				round_q <= '0;
			end else if (cmd.do_round) begin
				round_q <= (round_q == ROUND_LAST) ? 7'd0 : round_q + 7'd1;
			end
		end
	end

	assign last_round = (round_q == ROUND_LAST);
	assign chain      = chain_q;

endmodule
